// ----- hw/rtl/mffe_pkg.sv -----
// Shared constants and register indexes for the MAVLink frame field extractor.
`default_nettype none
package mffe_pkg;

  localparam int unsigned CNT_W = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [7:0]       START_BYTE = 8'hFE;
  localparam logic [CNT_W-1:0] ID_COUNT   = 9'd6;
  localparam logic [CNT_W-1:0] LEN_COUNT  = 9'd2;
  localparam logic [CNT_W-1:0] LEN_EXTRA  = 9'd8;

  localparam logic [7:0]       RST_TARGET_MSG_ID      = 8'd35;
  localparam logic [CNT_W-1:0] RST_EXPECTED_FRAME_LEN = 9'd30;
  localparam logic [CNT_W-1:0] RST_FIELD_LOW_POS      = 9'd21;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_MSG_ID      = 2'd0,
    CFG_EXPECTED_FRAME_LEN = 2'd1,
    CFG_FIELD_LOW_POS      = 2'd2
  } cfg_idx_e;

endpackage
`default_nettype wire

// ----- hw/rtl/mavlink_frame_field_extractor.sv -----
// Top level of the MAVLink v1 frame field extractor.
// A result is registered and appears in the cycle after the beat carrying the field's high byte.
// Throughput: one byte per cycle while the output is not stalled; the frame state updates in a single pass per beat.
// The output register lets a new byte enter whenever it is empty or as its result is taken.
// Reset clears the frame state and output valid and loads the register defaults.
`default_nettype none
module mavlink_frame_field_extractor
  import mffe_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            rx_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [15:0]                field_value_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] byte_count_q, byte_count_d;
  logic [CNT_W-1:0] frame_len_q, frame_len_d;
  logic             frame_match_q, frame_match_d;
  logic [7:0]       low_byte_q, low_byte_d;
  logic             out_valid_q, out_valid_d;
  logic [15:0]      field_value_q, field_value_d;

  logic [7:0]       target_msg_id_q;
  logic [CNT_W-1:0] expected_frame_len_q;
  logic [CNT_W-1:0] field_low_pos_q;

  logic             in_fire;
  logic             emit;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W:0]   high_pos;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = !out_valid_q || out_ready_i;
  assign in_fire       = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign field_value_o = field_value_q;

  assign count_inc = byte_count_q + 9'd1;
  assign high_pos  = {1'b0, field_low_pos_q} + 10'd1;

  always_comb begin
    phase_d       = phase_q;
    byte_count_d  = byte_count_q;
    frame_len_d   = frame_len_q;
    frame_match_d = frame_match_q;
    low_byte_d    = low_byte_q;
    emit          = 1'b0;
    case (phase_q)
      PH_LEN: begin
        byte_count_d  = LEN_COUNT;
        frame_len_d   = {1'b0, rx_byte_i} + LEN_EXTRA;
        frame_match_d = 1'b0;
        phase_d       = PH_BODY;
      end
      PH_BODY: begin
        byte_count_d = count_inc;
        if (count_inc >= frame_len_q) begin
          phase_d = PH_IDLE;
        end
        if (count_inc == ID_COUNT) begin
          frame_match_d = (rx_byte_i == target_msg_id_q) &&
                          (frame_len_q == expected_frame_len_q);
        end
        if (frame_match_d) begin
          if (count_inc == field_low_pos_q) begin
            low_byte_d = rx_byte_i;
          end
          if ({1'b0, count_inc} == high_pos) begin
            emit = 1'b1;
          end
        end
      end
      default: begin
        phase_d = (rx_byte_i == START_BYTE) ? PH_LEN : PH_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d   = out_valid_q;
    field_value_d = field_value_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && emit) begin
      out_valid_d   = 1'b1;
      field_value_d = {rx_byte_i, low_byte_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      byte_count_q  <= '0;
      frame_len_q   <= '0;
      frame_match_q <= 1'b0;
      low_byte_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q       <= phase_d;
        byte_count_q  <= byte_count_d;
        frame_len_q   <= frame_len_d;
        frame_match_q <= frame_match_d;
        low_byte_q    <= low_byte_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    field_value_q <= field_value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_msg_id_q      <= RST_TARGET_MSG_ID;
      expected_frame_len_q <= RST_EXPECTED_FRAME_LEN;
      field_low_pos_q      <= RST_FIELD_LOW_POS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TARGET_MSG_ID:      target_msg_id_q      <= cfg_data_i[7:0];
        CFG_EXPECTED_FRAME_LEN: expected_frame_len_q <= cfg_data_i;
        CFG_FIELD_LOW_POS:      field_low_pos_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mffe_checker.sv -----
// Port-level assertions for the MAVLink frame field extractor and their bind.
`default_nettype none
module mffe_checker
  import mffe_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic [7:0]            rx_byte_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [15:0]           field_value_o,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(field_value_o))
    else $error("result changed while stalled");

  // The output register frees the input side whenever it is empty or draining.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled with a free output register");

  // A new result only follows an accepted byte beat.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !in_fire) || (!out_valid_o && !in_fire)
      |=> !out_valid_o)
    else $error("result without an accepted byte");

  // Configuration writes are never held off.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

  logic unused_ok;
  assign unused_ok = ^{rx_byte_i, cfg_index_i, cfg_data_i};

endmodule

bind mavlink_frame_field_extractor mffe_checker u_mffe_checker (.*);
`default_nettype wire
